### src/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    // Default geometry
    localparam int HEAP_DEPTH_DEF  = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed result field widths
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_COUNT_W = 11;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

endpackage

### src/max_heap_priority_queue.sv
`timescale 1ns / 1ps

// Channel   | Signals                                             | Handshake
// ----------+-----------------------------------------------------+---------------------------
// command   | mode, value                                         | taken when start & !busy
// result    | removed_value, status, top_value, entry_count,      | valid for one cycle on done
//           | is_empty                                            |
//
// Insert climbs the new item toward the root; remove refills the root from the last entry
// and sinks it. An item that needs no sift (rejected, insert into an empty heap, remove
// of the last entry) goes straight from accept to the report state.
// The sift loop does one compare per level against a registered read of the heap
// memory (two read ports, one write port), with the next read issued alongside the write.
// Reset clears the entry count and control only; the heap memory is never cleared.
// The receiver cannot stall: done is a single-cycle strobe and busy drops right after.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   mode,
    input  logic signed [VALUE_WIDTH-1:0]          value,
    output logic                                   done,
    output logic signed [mhpq_pkg::OUT_VALUE_W-1:0] removed_value,
    output mhpq_pkg::status_t                      status,
    output logic signed [mhpq_pkg::OUT_VALUE_W-1:0] top_value,
    output logic [mhpq_pkg::OUT_COUNT_W-1:0]       entry_count,
    output logic                                   is_empty
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CMP = 3'd1;
    localparam logic [2:0] S_UP_FIN = 3'd2;
    localparam logic [2:0] S_RM_RD  = 3'd3;
    localparam logic [2:0] S_DN_CMP = 3'd4;
    localparam logic [2:0] S_REPORT = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    logic [VALUE_WIDTH-1:0] removed_reg, removed_next;
    mhpq_pkg::status_t      status_reg, status_next;

    // Heap memory: one write port, two registered read ports
    logic [VALUE_WIDTH-1:0] heap_mem [HEAP_DEPTH];
    logic                   mem_we;
    logic [AW-1:0]          mem_wa, mem_ra, mem_rb;
    logic [VALUE_WIDTH-1:0] mem_wd, rd_a_reg, rd_b_reg;

    // Tree index helpers
    logic [AW-1:0]          parent_idx;
    logic [AW-1:0]          ins_parent;
    logic [CW-1:0]          last_cnt;
    logic [XW-1:0]          left_x, right_x, count_x, best_x;
    logic [AW-1:0]          best_idx;
    logic                   use_l, use_r;
    logic [VALUE_WIDTH-1:0] best_val;

    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign ins_parent = AW'((count_reg - CW'(1)) >> 1);
    assign last_cnt   = count_reg - CW'(1);
    assign left_x     = XW'({idx_reg, 1'b1});
    assign right_x    = left_x + XW'(1);
    assign count_x    = XW'(count_reg);

    // Pick the larger child; left wins a tie, the moving value wins a tie with a child
    always_comb
    begin
        use_l    = (left_x < count_x) && ($signed(rd_a_reg) > $signed(cur_reg));
        best_val = use_l ? rd_a_reg : cur_reg;
        use_r    = (right_x < count_x) && ($signed(rd_b_reg) > $signed(best_val));
        if (use_r)
        begin
            best_val = rd_b_reg;
        end
        best_x   = use_r ? right_x : left_x;
        best_idx = best_x[AW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        top_next     = top_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_wa       = idx_reg;
        mem_wd       = cur_reg;
        mem_ra       = '0;
        mem_rb       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    status_next  = mhpq_pkg::ST_OK;
                    state_next   = S_REPORT;
                    if (mode == mhpq_pkg::MODE_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // Take the root, fetch the last entry to refill it
                            removed_next = top_reg;
                            count_next   = last_cnt;
                            mem_ra       = AW'(last_cnt);
                            if (last_cnt != '0)
                            begin
                                state_next = S_RM_RD;
                            end
                        end
                    end
                    else if (count_reg >= CW'(HEAP_DEPTH))
                    begin
                        status_next = mhpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        // Append at the end and start the climb
                        count_next = count_reg + CW'(1);
                        cur_next   = value;
                        idx_next   = AW'(count_reg);
                        if (count_reg == '0)
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = '0;
                            mem_wd   = value;
                            top_next = value;
                        end
                        else
                        begin
                            mem_ra     = ins_parent;
                            state_next = S_UP_CMP;
                        end
                    end
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if ($signed(cur_reg) > $signed(rd_a_reg))
                begin
                    // Pull the parent down and climb one level
                    mem_wd   = rd_a_reg;
                    idx_next = parent_idx;
                    mem_ra   = (parent_idx - AW'(1)) >> 1;
                    if (parent_idx == '0)
                    begin
                        state_next = S_UP_FIN;
                    end
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_UP_FIN:
            begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                top_next   = cur_reg;
                state_next = S_REPORT;
            end
            S_RM_RD:
            begin
                // Last entry arrives; sink it from the root
                cur_next   = rd_a_reg;
                idx_next   = '0;
                mem_ra     = AW'(1);
                mem_rb     = AW'(2);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (use_l || use_r)
                begin
                    // Lift the larger child and descend
                    mem_wd   = best_val;
                    idx_next = best_idx;
                    mem_ra   = AW'({best_idx, 1'b1});
                    mem_rb   = AW'({best_idx, 1'b1}) + AW'(1);
                    if (idx_reg == '0)
                    begin
                        top_next = best_val;
                    end
                end
                else
                begin
                    if (idx_reg == '0)
                    begin
                        top_next = cur_reg;
                    end
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        top_reg     <= top_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // Heap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= heap_mem[mem_ra];
        rd_b_reg <= heap_mem[mem_rb];
    end

    // Drive the result
    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_REPORT);
    assign status        = status_reg;
    assign removed_value = mhpq_pkg::OUT_VALUE_W'(removed_reg);
    assign top_value     = (count_reg == '0) ? '0 : mhpq_pkg::OUT_VALUE_W'(top_reg);
    assign entry_count   = mhpq_pkg::OUT_COUNT_W'(count_reg);
    assign is_empty      = (count_reg == '0);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count above depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after a result");

    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == mhpq_pkg::MODE_REMOVE && count_reg == '0)
        |=> (done && status_reg == mhpq_pkg::ST_EMPTY && count_reg == '0))
        else $error("remove on empty heap not rejected");

    a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(start) && !$past(busy)))
        else $error("entry count changed without an accepted item");

endmodule

### tb/sv/heap_queue_checker.sv
`timescale 1ns / 1ps

module heap_queue_checker #(
    parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic                                    mode,
    input  logic signed [VALUE_WIDTH-1:0]           value,
    input  logic                                    done,
    input  logic signed [mhpq_pkg::OUT_VALUE_W-1:0] removed_value,
    input  mhpq_pkg::status_t                       status,
    input  logic signed [mhpq_pkg::OUT_VALUE_W-1:0] top_value,
    input  logic [mhpq_pkg::OUT_COUNT_W-1:0]        entry_count,
    input  logic                                    is_empty,
    output int                                      mismatch_count,
    output int                                      pending_results
);

    typedef struct packed {
        logic [mhpq_pkg::OUT_VALUE_W-1:0] removed;
        mhpq_pkg::status_t                status;
        logic [mhpq_pkg::OUT_VALUE_W-1:0] top;
        logic [mhpq_pkg::OUT_COUNT_W-1:0] count;
        logic                             empty;
    } heap_result_t;

    // Shadow copy of the heap; only entries below shadow_count are ever read
    logic signed [VALUE_WIDTH-1:0] shadow_heap [HEAP_DEPTH];
    int                            shadow_count;
    heap_result_t                  expected_results [$];

    initial
    begin
        shadow_count    = 0;
        mismatch_count  = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void swap_entries(input int a, input int b);
        logic signed [VALUE_WIDTH-1:0] held;
        held           = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = held;
    endfunction

    // Apply one item to the shadow heap and return the result it should produce
    function automatic heap_result_t predict_heap_op(input logic op_mode,
                                                     input logic signed [VALUE_WIDTH-1:0] op_value);
        heap_result_t res;
        int           idx;
        int           parent;
        int           left;
        int           right;
        int           best;
        res = '0;
        if (op_mode == mhpq_pkg::MODE_REMOVE)
        begin
            if (shadow_count == 0)
            begin
                res.status = mhpq_pkg::ST_EMPTY;
            end
            else
            begin
                res.removed    = mhpq_pkg::OUT_VALUE_W'($unsigned(shadow_heap[0]));
                shadow_heap[0] = shadow_heap[shadow_count-1];
                shadow_count--;
                // Sink the new root; left child wins a tie, swap only on strictly larger
                idx = 0;
                while (1'b1)
                begin
                    left  = 2 * idx + 1;
                    right = 2 * idx + 2;
                    best  = idx;
                    if (left < shadow_count && shadow_heap[left] > shadow_heap[best])
                        best = left;
                    if (right < shadow_count && shadow_heap[right] > shadow_heap[best])
                        best = right;
                    if (best == idx)
                        break;
                    swap_entries(idx, best);
                    idx = best;
                end
            end
        end
        else if (shadow_count >= HEAP_DEPTH)
        begin
            res.status = mhpq_pkg::ST_FULL;
        end
        else
        begin
            shadow_heap[shadow_count] = op_value;
            shadow_count++;
            // Raise the new entry while strictly larger than its parent
            idx = shadow_count - 1;
            while (idx > 0)
            begin
                parent = (idx - 1) / 2;
                if (!(shadow_heap[idx] > shadow_heap[parent]))
                    break;
                swap_entries(idx, parent);
                idx = parent;
            end
        end
        if (shadow_count > 0)
            res.top = mhpq_pkg::OUT_VALUE_W'($unsigned(shadow_heap[0]));
        res.count = mhpq_pkg::OUT_COUNT_W'(shadow_count);
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    // Compare each result with the oldest expectation, then record a newly taken item
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (removed_value !== want.removed)
                        report_mismatch($sformatf("removed_value got %0d expected %0d",
                                                  removed_value, $signed(want.removed)));
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, want.status));
                    if (top_value !== want.top)
                        report_mismatch($sformatf("top_value got %0d expected %0d",
                                                  top_value, $signed(want.top)));
                    if (entry_count !== want.count)
                        report_mismatch($sformatf("entry_count got %0d expected %0d",
                                                  entry_count, want.count));
                    if (is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty got %0b expected %0b",
                                                  is_empty, want.empty));
                end
            end
            if (start && !busy)
                expected_results = {expected_results, predict_heap_op(mode, value)};
        end
        pending_results = expected_results.size();
    end

endmodule

### tb/sv/max_heap_priority_queue_test.sv
`timescale 1ns / 1ps

module max_heap_priority_queue_test;

    localparam int HEAP_DEPTH    = mhpq_pkg::HEAP_DEPTH_DEF;
    localparam int VALUE_WIDTH   = mhpq_pkg::VALUE_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 480;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                                    clk;
    logic                                    rst_n;
    logic                                    start;
    logic                                    busy;
    logic                                    mode;
    logic signed [VALUE_WIDTH-1:0]           value;
    logic                                    done;
    logic signed [mhpq_pkg::OUT_VALUE_W-1:0] removed_value;
    mhpq_pkg::status_t                       status;
    logic signed [mhpq_pkg::OUT_VALUE_W-1:0] top_value;
    logic [mhpq_pkg::OUT_COUNT_W-1:0]        entry_count;
    logic                                    is_empty;
    int                                      mismatch_count;
    int                                      pending_results;
    int                                      stall_cycles;
    logic                                    steady;

    max_heap_priority_queue #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .value         (value),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .top_value     (top_value),
        .entry_count   (entry_count),
        .is_empty      (is_empty)
    );

    heap_queue_checker #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .value           (value),
        .done            (done),
        .removed_value   (removed_value),
        .status          (status),
        .top_value       (top_value),
        .entry_count     (entry_count),
        .is_empty        (is_empty),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // End the run when neither side moves an item for too long
    initial
    begin
        stall_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return 0;
        else if (roll < 17)
            return $urandom_range(1, 3);
        else if (roll < 19)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Bias toward duplicates and the ends of the range
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_WIDTH'($urandom);
            4, 5, 6:    return VALUE_WIDTH'(int'($urandom_range(0, 16)) - 8);
            7:          return VAL_MAX;
            8:          return VAL_MIN;
            default:    return $urandom_range(0, 1) ? VAL_MAX - VALUE_WIDTH'($urandom_range(1, 3))
                                                    : VAL_MIN + VALUE_WIDTH'($urandom_range(1, 3));
        endcase
    endfunction

    // Hold an item on the command port until the block takes it
    task automatic issue_command(input logic cmd_mode,
                                 input logic signed [VALUE_WIDTH-1:0] cmd_value);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
            mode  <= 1'($urandom_range(0, 1));
            value <= VALUE_WIDTH'($urandom);
        end
        @(negedge clk);
        start <= 1'b1;
        mode  <= cmd_mode;
        value <= cmd_value;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    initial
    begin
        int bias;
        rst_n  = 1'b0;
        start  = 1'b0;
        mode   = mhpq_pkg::MODE_INSERT;
        value  = '0;
        steady = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: remove on empty, extremes, duplicates, drain past empty
        issue_command(mhpq_pkg::MODE_REMOVE, VAL_MAX);
        issue_command(mhpq_pkg::MODE_INSERT, VAL_MAX);
        issue_command(mhpq_pkg::MODE_INSERT, VAL_MIN);
        issue_command(mhpq_pkg::MODE_INSERT, '0);
        issue_command(mhpq_pkg::MODE_INSERT, -1);
        issue_command(mhpq_pkg::MODE_INSERT, 1);
        issue_command(mhpq_pkg::MODE_INSERT, VAL_MAX);
        issue_command(mhpq_pkg::MODE_INSERT, VAL_MIN);
        issue_command(mhpq_pkg::MODE_INSERT, 5);
        issue_command(mhpq_pkg::MODE_INSERT, 5);
        repeat (10) issue_command(mhpq_pkg::MODE_REMOVE, VALUE_WIDTH'($urandom));

        // Random mix with a drifting insert bias so the fill level wanders
        bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                bias   = 30 + 20 * $urandom_range(0, 3);
            end
            if ($urandom_range(0, 99) < bias)
                issue_command(mhpq_pkg::MODE_INSERT, pick_value());
            else
                issue_command(mhpq_pkg::MODE_REMOVE, VALUE_WIDTH'($urandom));
        end

        // Drop start and let outstanding results arrive
        @(negedge clk);
        start <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
